// ===== hdl/glos_pkg.sv =====
// Package for the grid line-of-sight unit: field widths, tile codes,
// configuration register indexes and default grid size.
// Depends on nothing; every other file but glos_ram imports it.
`default_nettype none

package glos_pkg;

    // Default grid size, used as the top-level parameter defaults.
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    // Field widths fixed by the item format.
    localparam int COORD_W    = 6;
    localparam int TILE_W     = 2;
    localparam int BOUND_W    = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = BOUND_W;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Tile codes.
    localparam logic [TILE_W-1:0] TILE_WALL     = 2'd0;
    localparam logic [TILE_W-1:0] TILE_FLOOR    = 2'd1;
    localparam logic [TILE_W-1:0] TILE_DOOR     = 2'd2;
    localparam logic [TILE_W-1:0] TILE_OBSTACLE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_COLS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_ROWS = 1'b1;

    // Bound register reset values.
    localparam logic [BOUND_W-1:0] MAP_COLS_RST = 7'd64;
    localparam logic [BOUND_W-1:0] MAP_ROWS_RST = 7'd64;

endpackage

`default_nettype wire

// ===== hdl/glos_if.sv =====
// Channel interfaces of the grid line-of-sight unit: request, response and
// configuration write channels, each with valid/ready and its payload.
// Depends on glos_pkg.
`default_nettype none

interface glos_req_if
    import glos_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] from_col;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] to_col;
    logic [COORD_W-1:0] to_row;
    logic [TILE_W-1:0]  tile_code;

    modport source (output valid, kind, from_col, from_row, to_col, to_row, tile_code,
                    input ready);
    modport sink   (input valid, kind, from_col, from_row, to_col, to_row, tile_code,
                    output ready);
endinterface

interface glos_rsp_if;
    logic valid;
    logic ready;
    logic line_clear;

    modport source (output valid, line_clear, input ready);
    modport sink   (input valid, line_clear, output ready);
endinterface

interface glos_cfg_if
    import glos_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/glos_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module glos_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/grid_line_of_sight_unit.sv =====
// Grid line-of-sight unit: tile map in RAM and a Bresenham walker that
// steps one cell per cycle. Depends on glos_pkg, glos_if and glos_ram.
//
// Usage. The request channel carries write beats (kind 0) that store one
// tile and query beats (kind 1) that ask whether every cell strictly between
// the start and end cells is in bounds and holds floor or door. Every request
// beat gives exactly one response beat; writes answer zero. The config
// channel is always ready and sets map_cols (index 0) and map_rows (index 1).
//
// Timing. After a write beat the unit passes through its finish state before
// the next request is taken. A query walks from the start cell toward the end
// cell: the walker advances one cell per cycle and reads one tile per cycle
// from the single RAM read port, and the tile read for the last intermediate
// cell returns in the cycle after its address. The walk then sees the end
// cell, and the finish state loads the response register once it is free.
//
// Reset. After rst_n is released the unit sweeps the map to wall, one cell a
// cycle, over all GRID_COLS * GRID_ROWS cells (4096 by default); request ready
// stays low during the sweep while config beats are still taken.
//
// Stalls. The response sits in an output register; a new request is taken
// while it waits, and a finished item holds until the register is free.
`default_nettype none

module grid_line_of_sight_unit
    import glos_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    glos_req_if.sink   req,
    glos_rsp_if.source rsp,
    glos_cfg_if.sink   cfg
);

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Registers and their next values.
    state_t               state_reg,     state_next;
    logic [AW-1:0]        clr_cnt_reg,   clr_cnt_next;
    logic [BOUND_W-1:0]   map_cols_reg,  map_cols_next;
    logic [BOUND_W-1:0]   map_rows_reg,  map_rows_next;
    logic [COORD_W-1:0]   cur_c_reg,     cur_c_next;
    logic [COORD_W-1:0]   cur_r_reg,     cur_r_next;
    logic [COORD_W-1:0]   end_c_reg,     end_c_next;
    logic [COORD_W-1:0]   end_r_reg,     end_r_next;
    logic [COORD_W-1:0]   dc_reg,        dc_next;
    logic [COORD_W-1:0]   dr_reg,        dr_next;
    logic                 sc_reg,        sc_next;
    logic                 sr_reg,        sr_next;
    logic signed [8:0]    err_reg,       err_next;
    logic                 chk_vld_reg,   chk_vld_next;
    logic                 chk_inb_reg,   chk_inb_next;
    logic                 clear_reg,     clear_next;
    logic                 out_vld_reg,   out_vld_next;
    logic                 out_clear_reg, out_clear_next;

    // RAM port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [TILE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [TILE_W-1:0] ram_rdata;

    // Walker step signals.
    logic signed [9:0]  err_ext;
    logic signed [9:0]  e2;
    logic signed [9:0]  dc_ext;
    logic signed [9:0]  dr_ext;
    logic signed [9:0]  err_sum;
    logic               step_c;
    logic               step_r;
    logic [COORD_W-1:0] nc;
    logic [COORD_W-1:0] nr;
    logic               at_end;
    logic               next_is_end;
    logic               nxt_inb;
    logic               tile_ok;
    logic               req_fire;
    logic               rsp_fire;

    // Address of a cell inside the grid.
    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row);
        int lin;
        lin = 32'(row) * GRID_COLS + 32'(col);
        return lin[AW-1:0];
    endfunction

    // Cell lies inside the physical grid.
    function automatic logic in_grid(input logic [COORD_W-1:0] col,
                                     input logic [COORD_W-1:0] row);
        return (32'(col) < GRID_COLS) && (32'(row) < GRID_ROWS);
    endfunction

    // Cell lies inside the grid and inside the configured bounds.
    function automatic logic in_bounds(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row,
                                       input logic [BOUND_W-1:0] cols,
                                       input logic [BOUND_W-1:0] rows);
        return in_grid(col, row) && ({1'b0, col} < cols) && ({1'b0, row} < rows);
    endfunction

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = out_vld_reg && rsp.ready;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid      = out_vld_reg;
    assign rsp.line_clear = out_clear_reg;

    // Shared step unit: one Bresenham step from the current cell.
    assign err_ext = {err_reg[8], err_reg};
    assign e2      = err_ext <<< 1;
    assign dc_ext  = signed'({4'b0000, dc_reg});
    assign dr_ext  = signed'({4'b0000, dr_reg});
    assign step_c  = (e2 > -dr_ext);
    assign step_r  = (e2 < dc_ext);
    assign err_sum = err_ext - (step_c ? dr_ext : 10'sd0) + (step_r ? dc_ext : 10'sd0);
    assign nc = step_c ? (sc_reg ? cur_c_reg + 6'd1 : cur_c_reg - 6'd1) : cur_c_reg;
    assign nr = step_r ? (sr_reg ? cur_r_reg + 6'd1 : cur_r_reg - 6'd1) : cur_r_reg;

    assign at_end      = (cur_c_reg == end_c_reg) && (cur_r_reg == end_r_reg);
    assign next_is_end = (nc == end_c_reg) && (nr == end_r_reg);
    assign nxt_inb     = in_bounds(nc, nr, map_cols_reg, map_rows_reg);
    assign tile_ok     = (ram_rdata == TILE_FLOOR) || (ram_rdata == TILE_DOOR);

    // RAM write port: clearing sweep or tile write beat.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = TILE_WALL;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (req_fire && (req.kind == KIND_WRITE) && in_grid(req.from_col, req.from_row))
        begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(req.from_col, req.from_row);
            ram_wdata = req.tile_code;
        end
    end

    // RAM read port follows the next cell of the walk.
    assign ram_raddr = in_grid(nc, nr) ? cell_addr(nc, nr) : '0;

    glos_ram #(
        .WIDTH (TILE_W),
        .DEPTH (DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic of the sequencer, bounds and output register.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        map_cols_next  = map_cols_reg;
        map_rows_next  = map_rows_reg;
        cur_c_next     = cur_c_reg;
        cur_r_next     = cur_r_reg;
        end_c_next     = end_c_reg;
        end_r_next     = end_r_reg;
        dc_next        = dc_reg;
        dr_next        = dr_reg;
        sc_next        = sc_reg;
        sr_next        = sr_reg;
        err_next       = err_reg;
        chk_vld_next   = chk_vld_reg;
        chk_inb_next   = chk_inb_reg;
        clear_next     = clear_reg;
        out_vld_next   = out_vld_reg;
        out_clear_next = out_clear_reg;

        // Configuration writes are taken in every state.
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_MAP_COLS: map_cols_next = cfg.data;
                CFG_MAP_ROWS: map_rows_next = cfg.data;
                default:      ;
            endcase
        end

        // The response register drains when the receiver takes the beat.
        if (rsp_fire)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cur_c_next   = req.from_col;
                    cur_r_next   = req.from_row;
                    end_c_next   = req.to_col;
                    end_r_next   = req.to_row;
                    sc_next      = (req.from_col < req.to_col);
                    sr_next      = (req.from_row < req.to_row);
                    dc_next      = (req.to_col > req.from_col) ? req.to_col - req.from_col
                                                               : req.from_col - req.to_col;
                    dr_next      = (req.to_row > req.from_row) ? req.to_row - req.from_row
                                                               : req.from_row - req.to_row;
                    err_next     = signed'(9'({3'b000, dc_next}) - 9'({3'b000, dr_next}));
                    chk_vld_next = 1'b0;
                    if (req.kind == KIND_QUERY)
                    begin
                        clear_next = 1'b1;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        clear_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_WALK:
            begin
                // Test the cell whose tile arrives from the RAM this cycle.
                if (chk_vld_reg && !(chk_inb_reg && tile_ok))
                begin
                    clear_next = 1'b0;
                end
                if (at_end)
                begin
                    chk_vld_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cur_c_next   = nc;
                    cur_r_next   = nr;
                    err_next     = err_sum[8:0];
                    chk_vld_next = !next_is_end;
                    chk_inb_next = nxt_inb;
                end
            end

            ST_FINISH:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next   = 1'b1;
                    out_clear_next = clear_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            map_cols_reg <= MAP_COLS_RST;
            map_rows_reg <= MAP_ROWS_RST;
            chk_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            map_cols_reg <= map_cols_next;
            map_rows_reg <= map_rows_next;
            chk_vld_reg  <= chk_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Walker payload registers.
    always_ff @(posedge clk)
    begin
        cur_c_reg     <= cur_c_next;
        cur_r_reg     <= cur_r_next;
        end_c_reg     <= end_c_next;
        end_r_reg     <= end_r_next;
        dc_reg        <= dc_next;
        dr_reg        <= dr_next;
        sc_reg        <= sc_next;
        sr_reg        <= sr_next;
        err_reg       <= err_next;
        chk_inb_reg   <= chk_inb_next;
        clear_reg     <= clear_next;
        out_clear_reg <= out_clear_next;
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the grid line-of-sight unit: drives tile writes and sight queries,
// predicts each line_clear from a local tile map and Bresenham walk, and checks beats.
// Depends on glos_pkg, glos_if and the grid_line_of_sight_unit RTL.
`default_nettype none

module tb_top;
    import glos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] from_col;
        logic [COORD_W-1:0] from_row;
        logic [COORD_W-1:0] to_col;
        logic [COORD_W-1:0] to_row;
        logic [TILE_W-1:0]  tile_code;
    } los_item_t;

    typedef struct {
        bit        clear;
        los_item_t item;
    } clear_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    glos_req_if req_ch ();
    glos_rsp_if rsp_ch ();
    glos_cfg_if cfg_ch ();

    grid_line_of_sight_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Local copy of the tile map and bound registers.
    logic [TILE_W-1:0]  tile_map [GRID_ROWS_DEF][GRID_COLS_DEF];
    logic [BOUND_W-1:0] cols_bound;
    logic [BOUND_W-1:0] rows_bound;

    clear_entry_t expected_clear [$];
    int           err_count;
    int           items_sent;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_arm = 1'b0;
    bit           rsp_hold = 1'b0;

    // Clock: 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int eff_cols();
        return (cols_bound < GRID_COLS_DEF) ? int'(cols_bound) : GRID_COLS_DEF;
    endfunction

    function automatic int eff_rows();
        return (rows_bound < GRID_ROWS_DEF) ? int'(rows_bound) : GRID_ROWS_DEF;
    endfunction

    // A cell is open when it is inside the active bounds and holds floor or door.
    function automatic bit cell_open(input int c, input int r);
        if (c < 0 || r < 0 || c >= eff_cols() || r >= eff_rows())
            return 1'b0;
        return tile_map[r][c] == TILE_FLOOR || tile_map[r][c] == TILE_DOOR;
    endfunction

    // Bresenham walk; collects the cells strictly between the two end cells,
    // each coded as row * GRID_COLS_DEF + col.
    function automatic void trace_line(input int c0, input int r0, input int c1,
                                       input int r1, output int cells[$]);
        int dc, dr, sc, sr, err, e2, c, r;
        cells = {};
        dc = (c1 > c0) ? c1 - c0 : c0 - c1;
        dr = (r1 > r0) ? r1 - r0 : r0 - r1;
        sc = (c0 < c1) ? 1 : -1;
        sr = (r0 < r1) ? 1 : -1;
        err = dc - dr;
        c = c0;
        r = r0;
        while (c != c1 || r != r1)
        begin
            e2 = 2 * err;
            if (e2 > -dr)
            begin
                err -= dr;
                c += sc;
            end
            if (e2 < dc)
            begin
                err += dc;
                r += sr;
            end
            if (c != c1 || r != r1)
                cells = {cells, r * GRID_COLS_DEF + c};
        end
    endfunction

    function automatic bit sight_ok(input los_item_t it);
        int cells[$];
        trace_line(int'(it.from_col), int'(it.from_row), int'(it.to_col),
                   int'(it.to_row), cells);
        foreach (cells[i])
            if (!cell_open(cells[i] % GRID_COLS_DEF, cells[i] / GRID_COLS_DEF))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic los_item_t mk_write(input int c, input int r, input logic [1:0] code);
        los_item_t it;
        it.kind      = KIND_WRITE;
        it.from_col  = COORD_W'(c);
        it.from_row  = COORD_W'(r);
        it.to_col    = COORD_W'($urandom_range(63));
        it.to_row    = COORD_W'($urandom_range(63));
        it.tile_code = code;
        return it;
    endfunction

    function automatic los_item_t mk_query(input int c0, input int r0, input int c1,
                                           input int r1);
        los_item_t it;
        it.kind      = KIND_QUERY;
        it.from_col  = COORD_W'(c0);
        it.from_row  = COORD_W'(r0);
        it.to_col    = COORD_W'(c1);
        it.to_row    = COORD_W'(r1);
        it.tile_code = TILE_W'($urandom_range(3));
        return it;
    endfunction

    // Offer one request beat, then update the map copy and queue the expected answer.
    task automatic send_item(input los_item_t it);
        clear_entry_t ent;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= it.kind;
        req_ch.from_col  <= it.from_col;
        req_ch.from_row  <= it.from_row;
        req_ch.to_col    <= it.to_col;
        req_ch.to_row    <= it.to_row;
        req_ch.tile_code <= it.tile_code;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        items_sent++;
        ent.item = it;
        if (it.kind == KIND_WRITE)
        begin
            tile_map[it.from_row][it.from_col] = it.tile_code;
            ent.clear = 1'b0;
        end
        else
        begin
            ent.clear = sight_ok(it);
        end
        expected_clear = {expected_clear, ent};
    endtask

    // Pave the cells between two end cells with floor or door, optionally
    // spoil one of them, then ask for sight along the line.
    task automatic send_paved_line(input int c0, input int r0, input int c1, input int r1,
                                   input bit spoil);
        int cells[$];
        int bad;
        logic [1:0] code;
        trace_line(c0, r0, c1, r1, cells);
        bad = (spoil && cells.size() > 0) ? $urandom_range(cells.size() - 1) : -1;
        foreach (cells[i])
        begin
            if (i == bad)
                code = $urandom_range(1) ? TILE_OBSTACLE : TILE_WALL;
            else
                code = $urandom_range(1) ? TILE_DOOR : TILE_FLOOR;
            send_item(mk_write(cells[i] % GRID_COLS_DEF, cells[i] / GRID_COLS_DEF, code));
        end
        send_item(mk_query(c0, r0, c1, r1));
    endtask

    // Drop request valid and wait until every outstanding beat has answered.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_clear.size() != 0)
            @(posedge clk);
    endtask

    // Write both bound registers while the unit is idle.
    task automatic write_bounds(input int cols, input int rows);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= CFG_MAP_COLS;
        cfg_ch.data  <= CFG_DATA_W'(cols);
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cols_bound = BOUND_W'(cols);
        cfg_ch.addr <= CFG_MAP_ROWS;
        cfg_ch.data <= CFG_DATA_W'(rows);
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        rows_bound = BOUND_W'(rows);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response side: random ready, long hold when asked, and the result check.
    initial
    begin : rsp_side
        clear_entry_t ent;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_clear.size() == 0)
                begin
                    report_mismatch("response beat with nothing pending");
                end
                else
                begin
                    ent = expected_clear.pop_front();
                    if (rsp_ch.line_clear !== ent.clear)
                        report_mismatch($sformatf(
                            "kind %0d (%0d,%0d)->(%0d,%0d): line_clear %b, expected %b",
                            ent.item.kind, ent.item.from_col, ent.item.from_row,
                            ent.item.to_col, ent.item.to_row, rsp_ch.line_clear,
                            ent.clear));
                end
            end
            rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here once armed.
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // End cells, degenerate lines, tile codes and the longest walks.
    task automatic test_directed_cases();
        send_item(mk_query(0, 0, 63, 63));
        send_item(mk_query(63, 0, 0, 63));
        send_item(mk_query(5, 5, 5, 5));
        send_item(mk_query(10, 10, 11, 11));
        send_item(mk_query(63, 63, 62, 63));
        send_item(mk_write(0, 0, TILE_FLOOR));
        send_item(mk_write(63, 63, TILE_DOOR));
        send_item(mk_write(63, 0, TILE_OBSTACLE));
        send_item(mk_write(62, 0, TILE_FLOOR));
        // End cell holds an obstacle, which must not matter.
        send_item(mk_query(61, 0, 63, 0));
        send_item(mk_query(63, 0, 61, 0));
        send_item(mk_write(62, 0, TILE_OBSTACLE));
        send_item(mk_query(61, 0, 63, 0));
        send_item(mk_write(62, 0, TILE_DOOR));
        send_item(mk_query(61, 0, 63, 0));
    endtask

    // Zero bounds, bounds beyond the grid, and edges at the last column and row.
    task automatic test_bound_registers();
        write_bounds(0, 0);
        send_item(mk_query(61, 0, 63, 0));
        send_item(mk_query(0, 0, 1, 0));
        // Stored even though it is outside the active bounds.
        send_item(mk_write(62, 1, TILE_FLOOR));
        write_bounds(127, 127);
        send_item(mk_query(61, 0, 63, 0));
        write_bounds(63, 64);
        send_item(mk_query(61, 0, 63, 0));
        write_bounds(62, 64);
        send_item(mk_query(61, 0, 63, 0));
        write_bounds(64, 1);
        send_item(mk_query(61, 0, 63, 0));
        send_item(mk_query(62, 0, 62, 2));
    endtask

    // Mostly paved lines with random content, plus stray queries and writes.
    task automatic test_random_lines(input int cols, input int rows, input int n_items,
                                     input int snd_pct, input int rcv_pct);
        int stop_at, pick, span, c0, r0, c1, r1;
        write_bounds(cols, rows);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                span = ($urandom_range(9) == 0) ? 63 : 6;
                c0 = $urandom_range((eff_cols() + 1 > 63) ? 63 : eff_cols() + 1);
                r0 = $urandom_range((eff_rows() + 1 > 63) ? 63 : eff_rows() + 1);
                c1 = c0 + $urandom_range(2 * span) - span;
                r1 = r0 + $urandom_range(2 * span) - span;
                c1 = (c1 < 0) ? 0 : (c1 > 63) ? 63 : c1;
                r1 = (r1 < 0) ? 0 : (r1 > 63) ? 63 : r1;
                send_paved_line(c0, r0, c1, r1, $urandom_range(3) == 0);
            end
            else if (pick < 85)
            begin
                send_item(mk_query($urandom_range(63), $urandom_range(63),
                                   $urandom_range(63), $urandom_range(63)));
            end
            else
            begin
                send_item(mk_write($urandom_range(63), $urandom_range(63),
                                   TILE_W'($urandom_range(3))));
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        write_bounds(64, 64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_arm = 1'b1;
        repeat (12)
            send_paved_line($urandom_range(60), $urandom_range(60),
                            $urandom_range(63), $urandom_range(63) % 4,
                            $urandom_range(1));
    endtask

    initial
    begin
        timeout_guard();
    end

    task automatic timeout_guard();
        #10_000_000;
        $display("** grid_line_of_sight_unit: FAILED **");
        $finish;
    endtask

    initial
    begin
        err_count     = 0;
        items_sent    = 0;
        send_idle_pct = 12;
        recv_idle_pct = 73;
        cols_bound    = MAP_COLS_RST;
        rows_bound    = MAP_ROWS_RST;
        foreach (tile_map[r, c])
            tile_map[r][c] = TILE_WALL;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_WRITE;
        req_ch.from_col  = '0;
        req_ch.from_row  = '0;
        req_ch.to_col    = '0;
        req_ch.to_row    = '0;
        req_ch.tile_code = TILE_WALL;
        cfg_ch.valid     = 1'b0;
        cfg_ch.addr      = CFG_MAP_COLS;
        cfg_ch.data      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_bound_registers();
        test_random_lines(64, 64, 200, 12, 73);
        test_random_lines(127, 100, 200, 12, 73);
        test_random_lines(17, 45, 200, 73, 12);
        test_random_lines(1, 64, 200, 73, 12);
        test_random_lines(64, 3, 200, 0, 0);
        test_random_lines(40, 64, 200, 0, 0);
        test_backpressure();

        drain();
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("** grid_line_of_sight_unit: PASSED **");
        else
            $display("** grid_line_of_sight_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
